FILE: rtl/core/pfa_pkg.sv
// Shared types and constants for the page frame allocator.
// Used by the top level and pfa_ffs (pfa_ram does not use it); depends on nothing.
package pfa_pkg;

    localparam int MAP_WORDS_DEF   = 16;
    localparam int COUNT_WIDTH_DEF = 8;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam int CFG_W     = 10;
    localparam int PAGE_W    = 9;
    localparam int FREE_W    = 10;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_COW   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOMEM    = 3'd1;
    localparam logic [2:0] ST_COPIED   = 3'd2;
    localparam logic [2:0] ST_WRITABLE = 3'd3;
    localparam logic [2:0] ST_NONE     = 3'd4;

    localparam logic CFG_TOTAL    = 1'b0;
    localparam logic CFG_RESERVED = 1'b1;

    localparam logic [CFG_W-1:0] TOTAL_RESET    = 10'd512;
    localparam logic [CFG_W-1:0] RESERVED_RESET = 10'd1;

    typedef struct packed {
        logic [1:0]        op;
        logic [PAGE_W-1:0] frame;
    } t_in_item;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [2:0]        status;
        logic [FREE_W-1:0] free_pages;
    } t_out_item;

endpackage

FILE: rtl/core/page_frame_allocator_refcount.sv
// Page frame allocator top level: sequencer, count adder and the two RAMs.
// Depends on pfa_pkg, pfa_ram and pfa_ffs.
//
// One item at a time; o_in_stall is high while an item is in work. After reset
// a clearing pass empties both RAMs before the first item is taken. Init sweeps
// every frame once, one per cycle. Alloc and a copy-on-write fault that copies
// scan the bitmap RAM one word per cycle through its single read port. A result
// sits in an output register, so an item can start while the last one waits;
// an item stays in its done state while that register still holds a stalled
// result.
module page_frame_allocator_refcount
    import pfa_pkg::*;
#(
    parameter int MAP_WORDS   = MAP_WORDS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int NUM_FRAMES = MAP_WORDS * WORD_BITS;
    localparam int WORD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int FRAME_W    = WORD_W + BIT_W;
    localparam int CMP_W      = (FRAME_W > CFG_W) ? FRAME_W : CFG_W;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_FREE_RD,
        S_COW_RD,
        S_SCAN,
        S_CNT_RD,
        S_COW_DEC,
        S_DONE
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_init, n_init;
    logic                   r_cow, n_cow;
    logic [FRAME_W-1:0]     r_sweep, n_sweep;
    logic [WORD_BITS-1:0]   r_acc, n_acc;
    logic [WORD_W-1:0]      r_word_idx, n_word_idx;
    logic [FRAME_W-1:0]     r_frame_idx, n_frame_idx;
    logic [FRAME_W-1:0]     r_got, n_got;
    logic [COUNT_WIDTH-1:0] r_old, n_old;
    logic [FREE_W-1:0]      r_free, n_free;
    logic [CFG_W-1:0]       r_total, n_total;
    logic [CFG_W-1:0]       r_reserved, n_reserved;
    logic [PAGE_W-1:0]      r_res_page, n_res_page;
    logic [2:0]             r_res_status, n_res_status;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out_data, n_out_data;

    logic                   bm_we;
    logic [WORD_W-1:0]      bm_waddr, bm_raddr;
    logic [WORD_BITS-1:0]   bm_wdata, bm_rdata;
    logic                   ct_we;
    logic [FRAME_W-1:0]     ct_waddr, ct_raddr;
    logic [COUNT_WIDTH-1:0] ct_wdata, ct_rdata;

    logic                   ffs_found;
    logic [BIT_W-1:0]       ffs_idx;

    // shared count unit: one adder, +1 or -1
    logic [COUNT_WIDTH-1:0] alu_a, alu_sum;
    logic                   alu_dec;

    logic [FRAME_W-1:0]     in_frame;
    logic                   in_range;
    logic [CMP_W-1:0]       sweep_ext;
    logic                   sweep_bit, sweep_low, sweep_last;
    logic [WORD_BITS-1:0]   acc_word;

    pfa_ram #(
        .WIDTH  (WORD_BITS),
        .DEPTH  (MAP_WORDS),
        .ADDR_W (WORD_W)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    pfa_ram #(
        .WIDTH  (COUNT_WIDTH),
        .DEPTH  (NUM_FRAMES),
        .ADDR_W (FRAME_W)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (ct_we),
        .i_waddr (ct_waddr),
        .i_wdata (ct_wdata),
        .i_raddr (ct_raddr),
        .o_rdata (ct_rdata)
    );

    pfa_ffs u_ffs (
        .i_word  (bm_rdata),
        .o_found (ffs_found),
        .o_idx   (ffs_idx)
    );

    assign alu_sum = alu_a + (alu_dec ? {COUNT_WIDTH{1'b1}} : COUNT_WIDTH'(1));

    assign in_frame = FRAME_W'(i_in_data.frame);
    assign in_range = (NUM_FRAMES >= 512) || (i_in_data.frame < PAGE_W'(NUM_FRAMES));

    assign sweep_ext  = CMP_W'(r_sweep);
    assign sweep_bit  = r_init && (sweep_ext >= CMP_W'(r_reserved))
                               && (sweep_ext < CMP_W'(r_total));
    assign sweep_low  = r_init && (sweep_ext < CMP_W'(r_reserved));
    assign sweep_last = (r_sweep == FRAME_W'(NUM_FRAMES - 1));
    assign acc_word   = r_acc | (WORD_BITS'(sweep_bit) << r_sweep[BIT_W-1:0]);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_state      = r_state;
        n_init       = r_init;
        n_cow        = r_cow;
        n_sweep      = r_sweep;
        n_acc        = r_acc;
        n_word_idx   = r_word_idx;
        n_frame_idx  = r_frame_idx;
        n_got        = r_got;
        n_old        = r_old;
        n_free       = r_free;
        n_total      = r_total;
        n_reserved   = r_reserved;
        n_res_page   = r_res_page;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;

        bm_we    = 1'b0;
        bm_waddr = r_frame_idx[FRAME_W-1:BIT_W];
        bm_wdata = bm_rdata;
        bm_raddr = r_word_idx + WORD_W'(1);
        ct_we    = 1'b0;
        ct_waddr = r_got;
        ct_wdata = alu_sum;
        ct_raddr = r_got;
        alu_a    = ct_rdata;
        alu_dec  = 1'b0;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TOTAL:    n_total    = i_cfg_data;
                CFG_RESERVED: n_reserved = i_cfg_data;
                default:      n_total    = r_total;
            endcase
        end

        // drop the result once the transfer completes
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_SWEEP: begin
                ct_we    = 1'b1;
                ct_waddr = r_sweep;
                ct_wdata = COUNT_WIDTH'(sweep_low);
                n_free   = r_free + FREE_W'(sweep_bit);
                n_sweep  = r_sweep + FRAME_W'(1);
                if (r_sweep[BIT_W-1:0] == BIT_W'(WORD_BITS - 1)) begin
                    bm_we    = 1'b1;
                    bm_waddr = r_sweep[FRAME_W-1:BIT_W];
                    bm_wdata = acc_word;
                    n_acc    = '0;
                end else begin
                    n_acc = acc_word;
                end
                if (sweep_last) begin
                    n_state = r_init ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                bm_raddr = (i_in_data.op == OP_ALLOC) ? '0 : in_frame[FRAME_W-1:BIT_W];
                ct_raddr = in_frame;
                if (i_in_valid) begin
                    n_frame_idx  = in_frame;
                    n_res_page   = '0;
                    n_res_status = ST_OK;
                    unique case (i_in_data.op)
                        OP_INIT: begin
                            n_state = S_SWEEP;
                            n_init  = 1'b1;
                            n_sweep = '0;
                            n_acc   = '0;
                            n_free  = '0;
                        end
                        OP_ALLOC: begin
                            n_cow      = 1'b0;
                            n_word_idx = '0;
                            if (r_free == '0) begin
                                n_res_status = ST_NOMEM;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_FREE: begin
                            n_state = in_range ? S_FREE_RD : S_DONE;
                        end
                        OP_COW: begin
                            if (in_range) begin
                                n_state = S_COW_RD;
                            end else begin
                                n_res_status = ST_NONE;
                                n_state      = S_DONE;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_FREE_RD: begin
                bm_we    = 1'b1;
                bm_wdata = bm_rdata | (WORD_BITS'(1) << r_frame_idx[BIT_W-1:0]);
                ct_we    = 1'b1;
                ct_waddr = r_frame_idx;
                alu_dec  = 1'b1;
                n_free   = r_free + FREE_W'(1);
                n_state  = S_DONE;
            end
            S_COW_RD: begin
                bm_raddr = '0;
                n_old    = ct_rdata;
                n_state  = S_DONE;
                if (ct_rdata > COUNT_WIDTH'(1)) begin
                    n_cow      = 1'b1;
                    n_word_idx = '0;
                    if (r_free == '0) begin
                        n_res_status = ST_NOMEM;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else if (ct_rdata == COUNT_WIDTH'(1)) begin
                    n_res_page   = PAGE_W'(r_frame_idx);
                    n_res_status = ST_WRITABLE;
                end else begin
                    n_res_status = ST_NONE;
                end
            end
            S_SCAN: begin
                ct_raddr = {r_word_idx, ffs_idx};
                if (ffs_found) begin
                    bm_we    = 1'b1;
                    bm_waddr = r_word_idx;
                    bm_wdata = bm_rdata & ~(WORD_BITS'(1) << ffs_idx);
                    n_got    = {r_word_idx, ffs_idx};
                    n_state  = S_CNT_RD;
                end else if (r_word_idx == WORD_W'(MAP_WORDS - 1)) begin
                    n_res_status = ST_NOMEM;
                    n_state      = S_DONE;
                end else begin
                    n_word_idx = r_word_idx + WORD_W'(1);
                end
            end
            S_CNT_RD: begin
                ct_we  = 1'b1;
                n_free = r_free - FREE_W'(1);
                if (r_cow) begin
                    // new frame may be the faulting one: decrement what was just written
                    if (r_got == r_frame_idx) begin
                        n_old = alu_sum;
                    end
                    n_state = S_COW_DEC;
                end else begin
                    n_res_page = PAGE_W'(r_got);
                    n_state    = S_DONE;
                end
            end
            S_COW_DEC: begin
                ct_we        = 1'b1;
                ct_waddr     = r_frame_idx;
                alu_a        = r_old;
                alu_dec      = 1'b1;
                n_res_page   = PAGE_W'(r_got);
                n_res_status = ST_COPIED;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid           = 1'b1;
                    n_out_data.page       = r_res_page;
                    n_out_data.status     = r_res_status;
                    n_out_data.free_pages = r_free;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_init      <= 1'b0;
            r_cow       <= 1'b0;
            r_sweep     <= '0;
            r_acc       <= '0;
            r_word_idx  <= '0;
            r_free      <= '0;
            r_total     <= TOTAL_RESET;
            r_reserved  <= RESERVED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_cow       <= n_cow;
            r_sweep     <= n_sweep;
            r_acc       <= n_acc;
            r_word_idx  <= n_word_idx;
            r_free      <= n_free;
            r_total     <= n_total;
            r_reserved  <= n_reserved;
            r_out_valid <= n_out_valid;
        end
        r_frame_idx  <= n_frame_idx;
        r_got        <= n_got;
        r_old        <= n_old;
        r_res_page   <= n_res_page;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
    end

endmodule

FILE: rtl/core/pfa_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// Holds the free bitmap and the reference counts; no package dependency.
module pfa_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/pfa_ffs.sv
// Find-first-set unit: lowest set bit of one bitmap word.
// Shared by every allocation scan; uses pfa_pkg for the word size.
module pfa_ffs
    import pfa_pkg::*;
(
    input  logic [WORD_BITS-1:0] i_word,
    output logic                 o_found,
    output logic [BIT_W-1:0]     o_idx
);

    always_comb begin
        o_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (i_word[i]) begin
                o_idx = BIT_W'(i);
            end
        end
    end

    assign o_found = |i_word;

endmodule
